FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; all sample on clk and are off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold
`define AST_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

// ante implies cons in the same cycle
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante implies cons in the next cycle
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/lsdp_pkg.sv
// ----------------------------------------------------------------------------
// lsdp_pkg
// Types and constants shared by the lot sizing planner.
// ----------------------------------------------------------------------------
`default_nettype none
package lsdp_pkg;

  localparam int COST_W  = 24;
  localparam int ENTRY_W = COST_W + 1;
  localparam int DEM_W   = 5;
  localparam int PS_W    = 5;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 10;

  localparam logic [COST_W-1:0]  COST_SAT  = {COST_W{1'b1}};
  localparam logic [ENTRY_W-1:0] ENT_INFEAS = {1'b1, {COST_W{1'b0}}};

  localparam logic [CIDX_W-1:0] REG_HOLD_RATE     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SETUP_FEE     = 3'd1;
  localparam logic [CIDX_W-1:0] REG_UNIT_COST     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_INITIAL_STOCK = 3'd3;
  localparam logic [CIDX_W-1:0] REG_STOCK_LIMIT   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_ORDER_CEIL    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_FINAL_EN      = 3'd6;
  localparam logic [CIDX_W-1:0] REG_FINAL_STOCK   = 3'd7;

  typedef struct packed {
    logic [4:0] demand;
    logic       last_period;
  } lsdp_in_t;

  typedef struct packed {
    logic [3:0]        period_index;
    logic [3:0]        order_qty;
    logic [COST_W-1:0] plan_cost;
    logic              feasible;
    logic              last_result;
  } lsdp_out_t;

  typedef struct packed {
    logic [7:0] hold_rate;
    logic [9:0] setup_fee;
    logic [7:0] unit_cost;
    logic [4:0] initial_stock;
    logic [4:0] stock_limit;
    logic [3:0] order_ceil;
    logic       final_stock_enable;
    logic [4:0] final_stock;
  } lsdp_cfg_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } lsdp_evl_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TERM, S_ROWD, S_ISSUE, S_DRAIN, S_WRB, S_TOT, S_TOTW, S_OUT
  } lsdp_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lot_sizing_dp_planner.sv
// Loading: items are taken while the block is idle. After the last item the
// backward pass fills the cost table, one order choice per cycle, as the table
// has a single read port. Each result is then read out by a forward pass and
// held until taken. No item is taken until done.
// Reset (rst_n low, synchronous) restores register defaults and empties the block.
// ----------------------------------------------------------------------------
// lot_sizing_dp_planner
// Backward DP lot sizing planner with forward plan readout.
// ----------------------------------------------------------------------------
`default_nettype none
module lot_sizing_dp_planner #(
  parameter int MAX_PERIODS = 16,
  parameter int STOCK_MAX   = 31,
  parameter int ORDER_MAX   = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lsdp_pkg::lsdp_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lsdp_pkg::lsdp_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsdp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lsdp_pkg::CDAT_W-1:0]   cfg_data
);
  import lsdp_pkg::*;

  localparam int L    = STOCK_MAX + 1;
  localparam int LW   = $clog2(L);
  localparam int OW   = $clog2(ORDER_MAX + 1);
  localparam int TW   = $clog2(MAX_PERIODS + 1);
  localparam int PW   = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
  localparam int DEPTH = (MAX_PERIODS + 1) * L;
  localparam int AW   = $clog2(DEPTH);
  localparam int AVW  = ((LW > DEM_W) ? LW : DEM_W) + OW + 1;
  localparam logic [LW-1:0] LMAX = LW'(STOCK_MAX);

  lsdp_state_t state_r, state_nxt;
  lsdp_cfg_t   cfg_r;

  logic [DEM_W-1:0]   dem_mem [MAX_PERIODS];
  logic [ENTRY_W-1:0] cost_mem [DEPTH];
  logic [ENTRY_W-1:0] cm_q;

  logic [TW-1:0]      cnt_r, n_r, t_r;
  logic [LW-1:0]      s_r;
  logic [OW-1:0]      o_r;
  logic               fwd_r, ok_r;
  logic [PS_W-1:0]    ps_r;
  logic [DEM_W-1:0]   dem_q_r;
  logic [COST_W-1:0]  total_r;
  lsdp_out_t          out_r;

  logic               p_vld_r;
  logic [OW-1:0]      p_o_r;
  logic [LW-1:0]      p_nx_r;

  logic [LW-1:0]      lim, fs_c, init_c, s_cur;
  logic [OW-1:0]      omax;
  logic [AVW-1:0]     avail, nxw;
  logic               o_ok, in_acc, last_row, last_out;
  logic [AW-1:0]      rd_addr, cm_waddr;
  logic [ENTRY_W-1:0] cm_wdata, best;
  logic               cm_we;
  logic [OW-1:0]      best_o;
  lsdp_evl_ctl_t      evl_ctl;

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{hold_rate: 8'd10, setup_fee: 10'd50, unit_cost: 8'd10,
                 initial_stock: 5'd1, stock_limit: 5'd20, order_ceil: 4'd5,
                 final_stock_enable: 1'b0, final_stock: 5'd0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOLD_RATE:     cfg_r.hold_rate          <= cfg_data[7:0];
        REG_SETUP_FEE:     cfg_r.setup_fee          <= cfg_data[9:0];
        REG_UNIT_COST:     cfg_r.unit_cost          <= cfg_data[7:0];
        REG_INITIAL_STOCK: cfg_r.initial_stock      <= cfg_data[4:0];
        REG_STOCK_LIMIT:   cfg_r.stock_limit        <= cfg_data[4:0];
        REG_ORDER_CEIL:    cfg_r.order_ceil         <= cfg_data[3:0];
        REG_FINAL_EN:      cfg_r.final_stock_enable <= cfg_data[0];
        REG_FINAL_STOCK:   cfg_r.final_stock        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamped limits
  always_comb begin
    lim    = (int'(cfg_r.stock_limit) > STOCK_MAX) ? LMAX : LW'(cfg_r.stock_limit);
    fs_c   = (int'(cfg_r.final_stock) > STOCK_MAX) ? LMAX : LW'(cfg_r.final_stock);
    init_c = (int'(cfg_r.initial_stock) > STOCK_MAX) ? LMAX : LW'(cfg_r.initial_stock);
    omax   = (int'(cfg_r.order_ceil) > ORDER_MAX) ? OW'(ORDER_MAX) : OW'(cfg_r.order_ceil);
  end

  assign in_acc   = in_valid && in_ready;
  assign last_row = (s_r == LMAX);
  assign last_out = (TW'(t_r + 1'b1) == n_r);

  // candidate closing stock for the current order
  always_comb begin
    s_cur = fwd_r ? LW'(ps_r) : s_r;
    avail = AVW'(s_cur) + AVW'(o_r);
    nxw   = avail - AVW'(dem_q_r);
    o_ok  = (avail >= AVW'(dem_q_r)) && (nxw <= AVW'(lim));
  end

  // cost table ports
  always_comb begin
    rd_addr = (AW'(t_r) + AW'(1)) * AW'(L) + AW'(LW'(nxw));
    if (state_r == S_TOT) rd_addr = AW'(init_c);
    cm_we    = 1'b0;
    cm_waddr = AW'(t_r) * AW'(L) + AW'(s_r);
    cm_wdata = best;
    if (state_r == S_TERM) begin
      cm_we    = 1'b1;
      cm_waddr = AW'(n_r) * AW'(L) + AW'(s_r);
      cm_wdata = (!cfg_r.final_stock_enable || s_r == fs_c) ? '0 : ENT_INFEAS;
    end else if (state_r == S_WRB && !fwd_r) begin
      cm_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) cost_mem[cm_waddr] <= cm_wdata;
    cm_q <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && int'(cnt_r) < MAX_PERIODS) dem_mem[PW'(cnt_r)] <= in_data.demand;
    if (state_r == S_ROWD) dem_q_r <= dem_mem[PW'(t_r)];
  end

  // order pipeline into the evaluator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= (state_r == S_ISSUE) && o_ok;
    end
    p_o_r  <= o_r;
    p_nx_r <= LW'(nxw);
  end

  assign evl_ctl.clr = (state_r == S_ISSUE) && (o_r == '0);
  assign evl_ctl.vld = p_vld_r;

  lsdp_best #(.LW(LW), .OW(OW)) u_best (
    .clk    (clk),
    .cfg    (cfg_r),
    .ctl    (evl_ctl),
    .ord    (p_o_r),
    .nx     (p_nx_r),
    .fut    (cm_q),
    .best   (best),
    .best_o (best_o)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_data.last_period) state_nxt = S_TERM;
      S_TERM:  if (last_row) state_nxt = S_ROWD;
      S_ROWD:  state_nxt = S_ISSUE;
      S_ISSUE: if (o_r == omax) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_WRB;
      S_WRB: begin
        if (fwd_r) state_nxt = S_OUT;
        else if (!last_row) state_nxt = S_ISSUE;
        else if (t_r == '0) state_nxt = S_TOT;
        else state_nxt = S_ROWD;
      end
      S_TOT:   state_nxt = S_TOTW;
      S_TOTW:  state_nxt = S_ROWD;
      S_OUT:   if (out_ready) state_nxt = last_out ? S_IDLE : S_ROWD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
  end
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fwd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (in_data.last_period) cnt_r <= '0;
        else if (int'(cnt_r) < MAX_PERIODS) cnt_r <= cnt_r + 1'b1;
        if (in_data.last_period) fwd_r <= 1'b0;
      end
      if (state_r == S_TOTW) fwd_r <= 1'b1;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.last_period) begin
          n_r <= (int'(cnt_r) < MAX_PERIODS) ? cnt_r + 1'b1 : cnt_r;
          s_r <= '0;
        end
      end
      S_TERM: begin
        s_r <= last_row ? '0 : s_r + 1'b1;
        if (last_row) t_r <= n_r - 1'b1;
      end
      S_ROWD:  o_r <= '0;
      S_ISSUE: o_r <= o_r + 1'b1;
      S_DRAIN: ;
      S_WRB: begin
        o_r <= '0;
        if (fwd_r) begin
          out_r.period_index <= 4'(t_r);
          out_r.order_qty    <= ok_r ? 4'(best_o) : 4'd0;
          out_r.plan_cost    <= total_r;
          out_r.feasible     <= ok_r;
          out_r.last_result  <= last_out;
          if (ok_r) ps_r <= ps_r + PS_W'(best_o) - dem_q_r;
        end else begin
          s_r <= last_row ? '0 : s_r + 1'b1;
          if (last_row && t_r != '0) t_r <= t_r - 1'b1;
        end
      end
      S_TOT: ;
      S_TOTW: begin
        ok_r    <= !cm_q[COST_W];
        total_r <= cm_q[COST_W] ? '0 : cm_q[COST_W-1:0];
        ps_r    <= PS_W'(init_c);
        t_r     <= '0;
      end
      S_OUT:   if (out_ready) t_r <= t_r + 1'b1;
      default: ;
    endcase
  end

`include "assert_macros.svh"

  `AST_NEVER(a_no_overlap, in_ready && out_valid)
  `AST_IMPL(a_fwd_read_only, fwd_r, !cm_we)
  `AST_NEXT(a_last_starts, in_valid && in_ready && in_data.last_period, !in_ready)

endmodule
`default_nettype wire

FILE: hw/rtl/lsdp_best.sv
// ----------------------------------------------------------------------------
// lsdp_best
// Prices one order choice against its cost-to-go and keeps the running best.
// ----------------------------------------------------------------------------
`default_nettype none
module lsdp_best #(
  parameter int LW = 5,
  parameter int OW = 4
) (
  input  logic                        clk,
  input  lsdp_pkg::lsdp_cfg_t         cfg,
  input  lsdp_pkg::lsdp_evl_ctl_t     ctl,
  input  logic [OW-1:0]               ord,
  input  logic [LW-1:0]               nx,
  input  logic [lsdp_pkg::ENTRY_W-1:0] fut,
  output logic [lsdp_pkg::ENTRY_W-1:0] best,
  output logic [OW-1:0]               best_o
);
  import lsdp_pkg::*;

  localparam int SW = COST_W + 2;

  logic [ENTRY_W-1:0] best_r;
  logic [OW-1:0]      best_o_r;
  logic [SW-1:0]      step;
  logic [SW-1:0]      order_part;
  logic [COST_W-1:0]  sat;
  logic               take;

  always_comb begin
    order_part = (ord != '0)
               ? SW'(cfg.setup_fee) + SW'(cfg.unit_cost) * SW'(ord) : '0;
    step = SW'(cfg.hold_rate) * SW'(nx) + order_part + SW'(fut[COST_W-1:0]);
    sat  = (step > SW'(COST_SAT)) ? COST_SAT : step[COST_W-1:0];
    take = ctl.vld && !fut[COST_W] && (best_r[COST_W] || sat < best_r[COST_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      best_r   <= ENT_INFEAS;
      best_o_r <= '0;
    end else if (take) begin
      best_r   <= {1'b0, sat};
      best_o_r <= ord;
    end
  end

  assign best   = best_r;
  assign best_o = best_o_r;

endmodule
`default_nettype wire

FILE: verif/lsdp_checker.sv
// ----------------------------------------------------------------------------
// lsdp_checker
// Watches the input, result and register ports of the lot sizing planner.
// Keeps its own copy of the registers and demand store and, on each
// horizon-closing item, runs the backward cost table and the forward plan
// to queue the expected per-period results, then compares each result taken.
// ----------------------------------------------------------------------------
module lsdp_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  lsdp_pkg::lsdp_in_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  lsdp_pkg::lsdp_out_t           out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lsdp_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lsdp_pkg::CDAT_W-1:0]   cfg_data,
  output int                            fails,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsdp_pkg::*;

  localparam int N_PER = 16;
  localparam int N_LVL = 32;

  logic [7:0] hold_c;
  logic [9:0] setup_c;
  logic [7:0] unit_c;
  logic [4:0] init_stock;
  logic [4:0] stock_lim;
  logic [3:0] order_lim;
  logic       final_en;
  logic [4:0] final_lvl;

  logic [4:0]         demands [N_PER];
  int                 horizon_len;
  logic [ENTRY_W-1:0] cost_tbl [N_PER+1][N_LVL];
  lsdp_out_t          plan_q [$];
  int                 fail_cnt = 0;

  assign pending = plan_q.size();
  assign fails   = fail_cnt;

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // cheapest order from stock s in period t; bit 24 set when nothing works
  function automatic logic [ENTRY_W-1:0] best_step(int t, int s, output int qty);
    int nx;
    logic [31:0] c, best;
    best = ENT_INFEAS;
    qty = 0;
    for (int q = 0; q <= order_lim; q++) begin
      if (s + q < demands[t]) continue;
      nx = s + q - demands[t];
      if (nx > stock_lim) continue;
      if (cost_tbl[t+1][nx][COST_W]) continue;
      c = hold_c * nx;
      if (q > 0) c += setup_c + unit_c * q;
      c += cost_tbl[t+1][nx][COST_W-1:0];
      if (c > COST_SAT) c = COST_SAT;
      if (best[COST_W] || c < best) begin
        best = c;
        qty = q;
      end
    end
    return best[ENTRY_W-1:0];
  endfunction

  task automatic plan_horizon();
    int n, stock, qty;
    logic [ENTRY_W-1:0] tot;
    lsdp_out_t r;
    n = horizon_len;
    horizon_len = 0;
    for (int s = 0; s < N_LVL; s++)
      cost_tbl[n][s] = (!final_en || s == final_lvl) ? '0 : ENT_INFEAS;
    for (int t = n - 1; t >= 0; t--)
      for (int s = 0; s < N_LVL; s++)
        cost_tbl[t][s] = best_step(t, s, qty);
    stock = init_stock;
    tot = cost_tbl[0][stock];
    for (int t = 0; t < n; t++) begin
      qty = 0;
      if (!tot[COST_W]) begin
        void'(best_step(t, stock, qty));
        stock = (stock + qty - demands[t]) & 31;
      end
      r.period_index = t[3:0];
      r.order_qty    = qty[3:0];
      r.plan_cost    = tot[COST_W] ? '0 : tot[COST_W-1:0];
      r.feasible     = !tot[COST_W];
      r.last_result  = (t + 1 == n);
      plan_q = {plan_q, r};
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_c      <= 8'd10;
      setup_c     <= 10'd50;
      unit_c      <= 8'd10;
      init_stock  <= 5'd1;
      stock_lim   <= 5'd20;
      order_lim   <= 4'd5;
      final_en    <= 1'b0;
      final_lvl   <= 5'd0;
      horizon_len = 0;
      plan_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOLD_RATE:     hold_c     <= cfg_data[7:0];
          REG_SETUP_FEE:     setup_c    <= cfg_data[9:0];
          REG_UNIT_COST:     unit_c     <= cfg_data[7:0];
          REG_INITIAL_STOCK: init_stock <= cfg_data[4:0];
          REG_STOCK_LIMIT:   stock_lim  <= cfg_data[4:0];
          REG_ORDER_CEIL:    order_lim  <= cfg_data[3:0];
          REG_FINAL_EN:      final_en   <= cfg_data[0];
          REG_FINAL_STOCK:   final_lvl  <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (plan_q.size() == 0) begin
          report("unexpected result period", int'(out_data.period_index), -1);
        end else begin
          lsdp_out_t w;
          w = plan_q.pop_front();
          if (out_data.period_index !== w.period_index)
            report("period_index", out_data.period_index, w.period_index);
          if (out_data.order_qty !== w.order_qty)
            report("order_qty", out_data.order_qty, w.order_qty);
          if (out_data.plan_cost !== w.plan_cost)
            report("plan_cost", out_data.plan_cost, w.plan_cost);
          if (out_data.feasible !== w.feasible)
            report("feasible", out_data.feasible, w.feasible);
          if (out_data.last_result !== w.last_result)
            report("last_result", out_data.last_result, w.last_result);
        end
      end
      if (in_valid && in_ready) begin
        // items past the horizon limit are dropped, their mark still counts
        if (horizon_len < N_PER) begin
          demands[horizon_len] = in_data.demand;
          horizon_len++;
        end
        if (in_data.last_period) plan_horizon();
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives demand items and register writes into the lot sizing planner under
// varying handshake pressure; the checker predicts and compares the plans.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lsdp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  lsdp_in_t  in_data;
  lsdp_out_t out_data;
  logic [CIDX_W-1:0] cfg_index;
  logic [CDAT_W-1:0] cfg_data;
  int fails, pending;
  int send_idle_pct, recv_idle_pct;
  int cycles = 0;
  int sent;

  always #5 clk = ~clk;

  lot_sizing_dp_planner dut (.*);

  lsdp_checker chk (.*);

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_item(int demand, bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.demand <= demand[4:0];
    in_data.last_period <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  task automatic set_reg(logic [CIDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CDAT_W-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // registers only move once the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_regs(int sc, int dc, int uc, int is, int sl, int mo, int fe, int fs);
    settle();
    set_reg(REG_HOLD_RATE, sc);
    set_reg(REG_SETUP_FEE, dc);
    set_reg(REG_UNIT_COST, uc);
    set_reg(REG_INITIAL_STOCK, is);
    set_reg(REG_STOCK_LIMIT, sl);
    set_reg(REG_ORDER_CEIL, mo);
    set_reg(REG_FINAL_EN, fe);
    set_reg(REG_FINAL_STOCK, fs);
  endtask

  // one random horizon; mostly short and servable, a few overflowing
  task automatic random_horizon(int order_cap);
    int len, pick, d;
    pick = $urandom_range(0, 99);
    len = pick < 80 ? $urandom_range(1, 5) : pick < 92 ? $urandom_range(6, 16)
                    : $urandom_range(17, 19);
    for (int i = 0; i < len; i++) begin
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                      : $urandom_range(0, order_cap);
      send_item(d, i == len - 1);
    end
  endtask

  task automatic random_phase(int s_pct, int r_pct, int cap, bit hold_once);
    int stop;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop = sent + 30;
    while (sent < stop) begin
      random_horizon(cap);
      if (hold_once) begin
        settle();
        hold_once = 0;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed, at reset settings: zero and full demand, short horizons
    send_item(0, 1);
    send_item(31, 1);
    send_item(3, 0); send_item(5, 0); send_item(0, 1);
    send_item(10, 0); send_item(21, 1);
    // large costs, full stock range, fixed final stock
    load_regs(255, 1023, 255, 31, 31, 15, 1, 31);
    send_item(15, 0); send_item(16, 0); send_item(31, 1);
    send_item(0, 1);
    // free ordering, no stock allowed, order must match demand
    load_regs(0, 0, 0, 0, 0, 15, 0, 0);
    send_item(15, 0); send_item(0, 0); send_item(16, 1);
    // opening stock above the limit, final stock forced to zero
    load_regs(1, 7, 2, 25, 3, 0, 1, 0);
    send_item(2, 0); send_item(20, 1);

    load_regs(10, 50, 10, 1, 20, 5, 0, 0);
    random_phase(19, 55, 7, 1'b0);
    load_regs($urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(0, 255),
              $urandom_range(0, 31), $urandom_range(8, 31), 15, 1, $urandom_range(0, 6));
    random_phase(55, 19, 14, 1'b1);
    load_regs(255, 1023, 255, 0, 31, 15, 0, 31);
    random_phase(0, 0, 15, 1'b0);

    settle();
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
